// ----- rtl/mga_pkg.sv -----
// shared constants, types and sine table for the matsubara green accumulator
// used by mga_bin_mem and matsubara_green_accumulator_unit
`timescale 1ns / 1ps
package mga_pkg;

  localparam int N_FREQ     = 256;
  localparam int ACC_W      = 48;
  localparam int STB        = 10;
  localparam int QUARTER    = 1 << (STB - 2);
  localparam int ADDR_W     = $clog2(N_FREQ);
  localparam int SIN_W      = 24;
  localparam int PHASE_W    = 25;

  localparam logic [1:0] FN_ACC   = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;
  localparam logic [1:0] FN_NOP   = 2'd3;

  localparam logic [1:0] CFG_FREQ_COUNT = 2'd0;
  localparam logic [1:0] CFG_INV_BETA   = 2'd1;
  localparam logic [1:0] CFG_RSVD_A     = 2'd2;
  localparam logic [1:0] CFG_RSVD_B     = 2'd3;

  typedef logic [22:0] qtab_t [0:QUARTER];

  typedef struct packed {
    logic signed [ACC_W-1:0] gre;
    logic signed [ACC_W-1:0] gim;
    logic signed [ACC_W-1:0] ere;
    logic signed [ACC_W-1:0] eim;
  } bin_t;

  function automatic qtab_t build_qtab();
    qtab_t q;
    logic [63:0] x, x2, t, s, v;
    for (int j = 0; j <= QUARTER; j++) begin
      x  = (64'(j) * 64'd1686629713) >> (STB - 2);
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 64'd110;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s + 64'd128) >> 8;
      if (v > 64'd4194304) v = 64'd4194304;
      q[j] = v[22:0];
    end
    return q;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic signed [SIN_W-1:0] sine_at(input logic [STB-1:0] idx);
    logic [1:0]       quad;
    logic [STB-3:0]   r;
    logic [22:0]      v;
    logic [STB-2:0]   ri;
    quad = idx[STB-1:STB-2];
    r    = idx[STB-3:0];
    ri   = (STB-1)'(QUARTER) - {1'b0, r};
    v    = quad[0] ? QTAB[ri] : QTAB[r];
    return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1])
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s[ACC_W-1:0];
  endfunction

endpackage

// ----- rtl/mga_bin_mem.sv -----
// bin memory: four accumulators per entry, one write and one registered read port
// per-entry valid bits give zero for never written or cleared entries; uses mga_pkg
`timescale 1ns / 1ps
module mga_bin_mem
  import mga_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  bin_t              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output bin_t              rdata
);

  bin_t              mem [0:N_FREQ-1];
  logic [N_FREQ-1:0] valid_r;
  bin_t              rd_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

// ----- rtl/matsubara_green_accumulator_unit.sv -----
// channel   | signals                                          | direction
// in        | in_valid in_ready in_func .. in_bin_index        | item in
// out       | out_valid out_ready out_green_real .. imag       | read result out
// cfg       | cfg_valid cfg_ready cfg_index cfg_data           | register write
// accumulate: min(freq_count, 256) bins, one bin read-modify-write per cycle through
// the bin memory's separate read and write ports; read: registered memory read, then waits on output stall
// clear and reset drop the per-bin valid bits at once, no sweep
// a waiting read result holds a following read until taken
// top level; uses mga_pkg and mga_bin_mem
`timescale 1ns / 1ps
module matsubara_green_accumulator_unit
  import mga_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [23:0]             in_annihilator_time,
  input  logic [23:0]             in_creator_time,
  input  logic signed [23:0]      in_matrix_element,
  input  logic                    in_sign_negative,
  input  logic signed [23:0]      in_prefactor,
  input  logic [7:0]              in_bin_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] out_green_real,
  output logic signed [ACC_W-1:0] out_green_imag,
  output logic signed [ACC_W-1:0] out_estimator_real,
  output logic signed [ACC_W-1:0] out_estimator_imag,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [23:0]             cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CVAL, S_RUN, S_RDW} state_t;

  localparam int CNT_W = ADDR_W + 1;
  localparam int C_W   = 33;
  localparam int G_W   = 36;
  localparam int E_W   = 41;

  state_t                    state_r;
  logic [8:0]                freq_count_r;
  logic [23:0]               inv_beta_r;
  logic signed [24:0]        m_r;
  logic signed [23:0]        f_r;
  logic [PHASE_W-1:0]        d_r;
  logic signed [49:0]        prod_r;
  logic signed [C_W-1:0]     c_r;
  logic [CNT_W-1:0]          k_r, cnt_r;
  logic [PHASE_W-1:0]        p_r;
  logic                      out_valid_r;
  bin_t                      out_r;

  logic [5:1]                sv_r;
  logic [ADDR_W-1:0]         a1_r, a2_r, a3_r, a4_r, a5_r;
  logic [STB-1:0]            idx1_r;
  logic signed [SIN_W-1:0]   sn2_r, cs2_r;
  logic signed [C_W+SIN_W-1:0] pre3_r, pim3_r;
  logic signed [G_W-1:0]     gre4_r, gim4_r, gre5_r, gim5_r;
  logic signed [G_W+23:0]    ere5_r, eim5_r;

  logic                      acc_xfer, issue, clr, mem_re, mem_we;
  logic [ADDR_W-1:0]         mem_raddr;
  bin_t                      mem_rdata, mem_wdata;
  logic signed [C_W+SIN_W:0] rre, rim;
  logic signed [G_W+24:0]    rere, reim;
  logic signed [50:0]        rc;
  logic signed [E_W-1:0]     ere, eim;
  logic signed [24:0]        mx;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign acc_xfer  = in_valid && in_ready;
  assign cfg_ready = rst_n;
  assign issue     = (state_r == S_RUN) && (k_r < cnt_r);
  assign clr       = acc_xfer && (in_func == FN_CLEAR);
  assign mem_re    = (acc_xfer && (in_func == FN_READ)) || sv_r[4];
  assign mem_raddr = sv_r[4] ? a4_r : in_bin_index;
  assign mem_we    = sv_r[5];
  assign mx        = {in_matrix_element[23], in_matrix_element};

  assign rc   = {prod_r[49], prod_r} + 51'sd32768;
  assign rre  = {pre3_r[C_W+SIN_W-1], pre3_r} + (C_W+SIN_W+1)'(2097152);
  assign rim  = {pim3_r[C_W+SIN_W-1], pim3_r} + (C_W+SIN_W+1)'(2097152);
  assign rere = {ere5_r[G_W+23], ere5_r} + (G_W+25)'(524288);
  assign reim = {eim5_r[G_W+23], eim5_r} + (G_W+25)'(524288);
  assign ere  = rere[G_W+24:20];
  assign eim  = reim[G_W+24:20];

  always_comb begin
    mem_wdata.gre = sat_add(mem_rdata.gre, ACC_W'(gre5_r));
    mem_wdata.gim = sat_add(mem_rdata.gim, ACC_W'(gim5_r));
    mem_wdata.ere = sat_add(mem_rdata.ere, ACC_W'(ere));
    mem_wdata.eim = sat_add(mem_rdata.eim, ACC_W'(eim));
  end

  mga_bin_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr),
    .we    (mem_we),
    .waddr (a5_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc_xfer) begin
      m_r <= in_sign_negative ? mx : -mx;
      f_r <= in_prefactor;
      d_r <= {1'b0, in_annihilator_time} - {1'b0, in_creator_time};
    end
    prod_r <= m_r * $signed({1'b0, inv_beta_r});
    if (state_r == S_CVAL) begin
      c_r <= rc[C_W+15:16];
    end
    if (state_r == S_CVAL) begin
      p_r <= d_r;
    end else if (issue) begin
      p_r <= p_r + {d_r[PHASE_W-2:0], 1'b0};
    end
    a1_r   <= k_r[ADDR_W-1:0];
    idx1_r <= p_r[PHASE_W-1:PHASE_W-STB];
    a2_r   <= a1_r;
    sn2_r  <= sine_at(idx1_r);
    cs2_r  <= sine_at(idx1_r + STB'(QUARTER));
    a3_r   <= a2_r;
    pre3_r <= c_r * cs2_r;
    pim3_r <= c_r * sn2_r;
    a4_r   <= a3_r;
    gre4_r <= rre[C_W+SIN_W:22];
    gim4_r <= rim[C_W+SIN_W:22];
    a5_r   <= a4_r;
    gre5_r <= gre4_r;
    gim5_r <= gim4_r;
    ere5_r <= f_r * gre4_r;
    eim5_r <= f_r * gim4_r;
  end

  // control, configuration and output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      freq_count_r <= 9'd256;
      inv_beta_r   <= 24'd65536;
      sv_r         <= '0;
      k_r          <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FREQ_COUNT) freq_count_r <= cfg_data[8:0];
        else if (cfg_index == CFG_INV_BETA) inv_beta_r <= cfg_data;
      end
      sv_r <= {sv_r[4:1], issue};
      if (out_valid_r && out_ready && (state_r != S_RDW)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc_xfer) begin
            if (in_func == FN_ACC) state_r <= S_MUL;
            else if (in_func == FN_READ) state_r <= S_RDW;
          end
        end
        S_MUL: state_r <= S_CVAL;
        S_CVAL: begin
          k_r     <= '0;
          cnt_r   <= (freq_count_r > 9'(N_FREQ)) ? CNT_W'(N_FREQ) : CNT_W'(freq_count_r);
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (issue) k_r <= k_r + 1'b1;
          else if (sv_r == '0) state_r <= S_IDLE;
        end
        S_RDW: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r       <= mem_rdata;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_green_real     = out_r.gre;
  assign out_green_imag     = out_r.gim;
  assign out_estimator_real = out_r.ere;
  assign out_estimator_imag = out_r.eim;

endmodule

// ----- rtl/mga_checker.sv -----
// port-level checks for matsubara_green_accumulator_unit
// bound to the top level; uses mga_pkg
`timescale 1ns / 1ps
module mga_port_props
  import mga_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       in_func,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ACC_W-1:0] out_green_real,
  input logic             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_green_real))
    else $error("result changed while stalled");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FN_ACC || in_func == FN_READ) |=> !in_ready)
    else $error("new transfer taken while busy");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without read");

endmodule

bind matsubara_green_accumulator_unit mga_port_props u_mga_port_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_green_real (out_green_real),
  .cfg_ready      (cfg_ready)
);

// ----- test/mga_checker.sv -----
// scoreboard for the matsubara green accumulator: tracks bin state and registers,
// predicts read results and compares every out transfer; uses mga_pkg
`timescale 1ns / 1ps
module mga_checker
  import mga_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [23:0]             in_annihilator_time,
  input  logic [23:0]             in_creator_time,
  input  logic signed [23:0]      in_matrix_element,
  input  logic                    in_sign_negative,
  input  logic signed [23:0]      in_prefactor,
  input  logic [7:0]              in_bin_index,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [ACC_W-1:0] out_green_real,
  input  logic signed [ACC_W-1:0] out_green_imag,
  input  logic signed [ACC_W-1:0] out_estimator_real,
  input  logic signed [ACC_W-1:0] out_estimator_imag,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [23:0]             cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct {
    logic [ACC_W-1:0] gre;
    logic [ACC_W-1:0] gim;
    logic [ACC_W-1:0] ere;
    logic [ACC_W-1:0] eim;
  } bin_read_t;

  longint    quarter_wave [0:QUARTER];
  longint    green_re [N_FREQ];
  longint    green_im [N_FREQ];
  longint    est_re [N_FREQ];
  longint    est_im [N_FREQ];
  int        bin_count;
  longint    recip_beta;
  bin_read_t read_q [$];

  initial begin
    longint unsigned x, x2, t, s, v;
    for (int j = 0; j <= QUARTER; j++) begin
      x  = (longint'(j) * 64'd1686629713) >> (STB - 2);
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 110;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s + 128) >> 8;
      if (v > 64'd4194304) v = 64'd4194304;
      quarter_wave[j] = longint'(v);
    end
  end

  function automatic longint wave_at(int idx);
    int     quad;
    int     r;
    longint v;
    quad = (idx >> (STB - 2)) & 3;
    r    = idx & (QUARTER - 1);
    v    = (quad & 1) ? quarter_wave[QUARTER - r] : quarter_wave[r];
    return (quad & 2) ? -v : v;
  endfunction

  function automatic longint round_q(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat_sum(longint acc, longint g);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ACC_W - 1)) - 1;
    lo = -hi - 1;
    if (g > 0 && acc > hi - g) return hi;
    if (g < 0 && acc < lo - g) return lo;
    return acc + g;
  endfunction

  task automatic accumulate_pair();
    longint      m;
    longint      c;
    longint      f;
    longint      g_re;
    longint      g_im;
    logic [24:0] d;
    logic [24:0] p;
    int          count;
    int          idx;
    m = longint'(in_matrix_element);
    f = longint'(in_prefactor);
    if (!in_sign_negative) m = -m;
    c = round_q(m * recip_beta, 16);
    d = {1'b0, in_annihilator_time} - {1'b0, in_creator_time};
    count = (bin_count < N_FREQ) ? bin_count : N_FREQ;
    for (int k = 0; k < count; k++) begin
      p    = 25'((longint'(2 * k + 1) * longint'(d)));
      idx  = int'(p >> (PHASE_W - STB));
      g_re = round_q(c * wave_at(idx + QUARTER), 22);
      g_im = round_q(c * wave_at(idx), 22);
      green_re[k] = sat_sum(green_re[k], g_re);
      green_im[k] = sat_sum(green_im[k], g_im);
      est_re[k]   = sat_sum(est_re[k], round_q(f * g_re, 20));
      est_im[k]   = sat_sum(est_im[k], round_q(f * g_im, 20));
    end
  endtask

  task automatic clear_bins();
    for (int k = 0; k < N_FREQ; k++) begin
      green_re[k] = 0;
      green_im[k] = 0;
      est_re[k]   = 0;
      est_im[k]   = 0;
    end
  endtask

  task automatic check_field(string name, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bin_read_t e;
    int        b;
    if (!rst_n) begin
      bin_count  = 256;
      recip_beta = 65536;
      clear_bins();
      read_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (read_q.size() == 0) begin
          $display("%0t unexpected out transfer %h %h %h %h", $time, out_green_real,
                   out_green_imag, out_estimator_real, out_estimator_imag);
          fail_count++;
        end else begin
          e = read_q.pop_front();
          check_field("green_real", e.gre, out_green_real);
          check_field("green_imag", e.gim, out_green_imag);
          check_field("estimator_real", e.ere, out_estimator_real);
          check_field("estimator_imag", e.eim, out_estimator_imag);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FREQ_COUNT) bin_count = int'(cfg_data[8:0]);
        else if (cfg_index == CFG_INV_BETA) recip_beta = longint'(cfg_data);
      end
      if (in_valid && in_ready) begin
        case (in_func)
          FN_ACC: accumulate_pair();
          FN_READ: begin
            b = int'(in_bin_index);
            e.gre = green_re[b][ACC_W-1:0];
            e.gim = green_im[b][ACC_W-1:0];
            e.ere = est_re[b][ACC_W-1:0];
            e.eim = est_im[b][ACC_W-1:0];
            read_q.push_back(e);
          end
          FN_CLEAR: clear_bins();
          default: ;
        endcase
      end
    end
    pending <= read_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// top of the matsubara green accumulator testbench: clock, reset, stimulus and verdict
// depends on mga_pkg, matsubara_green_accumulator_unit and mga_checker
`timescale 1ns / 1ps
module tb_top;
  import mga_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN       = 300;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_func;
  logic [23:0]             in_annihilator_time;
  logic [23:0]             in_creator_time;
  logic signed [23:0]      in_matrix_element;
  logic                    in_sign_negative;
  logic signed [23:0]      in_prefactor;
  logic [7:0]              in_bin_index;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [ACC_W-1:0] out_green_real;
  logic signed [ACC_W-1:0] out_green_imag;
  logic signed [ACC_W-1:0] out_estimator_real;
  logic signed [ACC_W-1:0] out_estimator_imag;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [1:0]              cfg_index;
  logic [23:0]             cfg_data;
  int                      fail_count;
  int                      pending;
  int                      cycles;
  int                      stall_left;
  bit                      stall_free;

  matsubara_green_accumulator_unit dut (.*);
  mga_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (stall_free || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // result side back-pressure, with stretches of none
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= gap_len();
    end
  end

  task automatic send_item(logic [1:0] fn, logic [23:0] tc, logic [23:0] td,
                           logic [23:0] m, logic neg, logic [23:0] f, logic [7:0] b);
    int g;
    in_valid            <= 1'b1;
    in_func             <= fn;
    in_annihilator_time <= tc;
    in_creator_time     <= td;
    in_matrix_element   <= m;
    in_sign_negative    <= neg;
    in_prefactor        <= f;
    in_bin_index        <= b;
    do @(posedge clk); while (!in_ready);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic random_item();
    int          r;
    logic [1:0]  fn;
    logic [23:0] m;
    logic [23:0] f;
    r = $urandom_range(0, 99);
    if (r < 45) fn = FN_ACC;
    else if (r < 90) fn = FN_READ;
    else if (r < 95) fn = FN_CLEAR;
    else fn = FN_NOP;
    m = 24'($urandom());
    f = 24'($urandom());
    if ($urandom_range(0, 9) == 0) m = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {23{m[0]}}};
    send_item(fn, 24'($urandom()), 24'($urandom()), m, 1'($urandom()), f,
              8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    int counts [10];
    int betas [10];
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_func             = FN_READ;
    in_annihilator_time = '0;
    in_creator_time     = '0;
    in_matrix_element   = '0;
    in_sign_negative    = 1'b0;
    in_prefactor        = '0;
    in_bin_index        = '0;
    cfg_valid           = 1'b0;
    cfg_index           = CFG_FREQ_COUNT;
    cfg_data            = '0;
    stall_free          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at reset register values
    send_item(FN_ACC, 24'hFFFFFF, 24'h000000, 24'h7FFFFF, 1'b0, 24'h7FFFFF, 8'd0);
    send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'd0);
    send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'd255);
    send_item(FN_ACC, 24'h000000, 24'hFFFFFF, 24'h800000, 1'b1, 24'h800000, 8'd0);
    send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'd1);
    send_item(FN_ACC, 24'h400000, 24'h400000, 24'h100000, 1'b0, 24'h000000, 8'd0);
    send_item(FN_ACC, 24'h800000, 24'h000000, 24'h000001, 1'b1, 24'hFFFFFF, 8'd0);
    send_item(FN_NOP, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 8'd255);
    send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'd128);
    send_item(FN_READ, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 8'd255);
    send_item(FN_CLEAR, '0, '0, '0, 1'b0, '0, 8'd0);
    send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'd0);
    send_item(FN_ACC, 24'h123456, 24'h654321, 24'h0ABCDE, 1'b0, 24'hF00000, 8'd0);
    send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'd255);
    settle();

    counts = '{0, 1, 256, 511, 3, 17, 100, 40, 257, 9};
    betas  = '{1234, 0, 16777215, 65536, 1, 300000, 8388608, 65536, 70000, 16777215};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_FREQ_COUNT, 24'(counts[ph]));
      write_reg(CFG_INV_BETA, 24'(betas[ph]));
      if (ph == 4) write_reg(CFG_RSVD_A, 24'($urandom()));
      if (ph == 6) write_reg(CFG_RSVD_B, 24'($urandom()));
      send_item(FN_ACC, 24'($urandom()), 24'($urandom()), 24'h7FFFFF, 1'b1, 24'h800000,
                8'd0);
      send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'(counts[ph] > 0 ? counts[ph] - 1 : 0));
      send_item(FN_READ, '0, '0, '0, 1'b0, '0, 8'(counts[ph] < 255 ? counts[ph] : 255));
      stall_free = (ph == 3 || ph == 7);
      for (int i = 0; i < 113; i++) random_item();
      stall_free = 1'b0;
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
